@@ rtl/core/ordered_array_insert_delete_search_top_assert.svh @@
// Assertion macros shared by the ordered array RTL.
`ifndef ORDERED_ARRAY_INSERT_DELETE_SEARCH_TOP_ASSERT_SVH
`define ORDERED_ARRAY_INSERT_DELETE_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OAIDS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define OAIDS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/oaids_pkg.sv @@
// Shared types and constants for the ordered array block.
package oaids_pkg;

    localparam int CAPACITY = 256;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 9;
    localparam int POS_W    = 9;
    localparam int KIND_W   = 2;
    localparam int STS_W    = 2;

    typedef enum logic [KIND_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_READ   = 2'd3
    } req_kind_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_RANGE = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_TAIL,
        ST_PUT,
        ST_DONE
    } state_t;

    typedef struct packed {
        req_kind_t                 kind;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  value;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic                      found;
        logic signed [DATA_W-1:0]  read_value;
        logic [CNT_W-1:0]          count;
    } res_t;

endpackage

@@ rtl/core/oaids_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
module oaids_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/oaids_ctrl.sv @@
// Request sequencer: walks the entry RAM to shift, search or read.
`include "ordered_array_insert_delete_search_top_assert.svh"

module oaids_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  oaids_pkg::req_t   req,
    output logic              res_valid,
    input  logic              res_ready,
    output oaids_pkg::res_t   res
);

    localparam int AW = oaids_pkg::ADDR_W;
    localparam int CW = oaids_pkg::CNT_W;
    localparam int DW = oaids_pkg::DATA_W;

    oaids_pkg::state_t    state_reg, state_next;
    oaids_pkg::req_kind_t kind_reg, kind_next;
    oaids_pkg::status_t   status_reg, status_next;
    logic [DW-1:0]        value_reg, value_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        last_reg, last_next;
    logic [AW-1:0]        paddr_reg, paddr_next;
    logic                 pend_reg, pend_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 found_reg, found_next;
    logic [DW-1:0]        rdval_reg, rdval_next;

    // decode of the incoming beat
    oaids_pkg::status_t   dec_status;
    oaids_pkg::state_t    dec_target;
    logic [AW-1:0]        dec_ptr;
    logic [AW-1:0]        dec_last;
    logic [CW-1:0]        dec_count;
    logic [CW-1:0]        cnt_m1;
    logic                 accept;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [DW-1:0]        ram_wdata, ram_rdata;

    oaids_ram #(
        .DEPTH (oaids_pkg::CAPACITY),
        .WIDTH (DW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cnt_m1 = count_reg - CW'(1);
    assign accept = req_valid && req_ready;

    always_comb begin
        dec_status = oaids_pkg::STS_OK;
        dec_target = oaids_pkg::ST_DONE;
        dec_ptr    = '0;
        dec_last   = '0;
        dec_count  = count_reg;
        unique case (req.kind)
            oaids_pkg::REQ_INSERT: begin
                if (req.position > count_reg) begin
                    dec_status = oaids_pkg::STS_RANGE;
                end else if (count_reg == CW'(oaids_pkg::CAPACITY)) begin
                    dec_status = oaids_pkg::STS_FULL;
                end else begin
                    dec_count = count_reg + CW'(1);
                    if (req.position == count_reg) begin
                        dec_target = oaids_pkg::ST_PUT;
                    end else begin
                        // shift the tail up, top entry first
                        dec_target = oaids_pkg::ST_WALK;
                        dec_ptr    = cnt_m1[AW-1:0];
                        dec_last   = req.position[AW-1:0];
                    end
                end
            end
            oaids_pkg::REQ_DELETE: begin
                if (req.position >= count_reg) begin
                    dec_status = oaids_pkg::STS_RANGE;
                end else begin
                    dec_count = cnt_m1;
                    if (req.position != cnt_m1) begin
                        dec_target = oaids_pkg::ST_WALK;
                        dec_ptr    = req.position[AW-1:0] + AW'(1);
                        dec_last   = cnt_m1[AW-1:0];
                    end
                end
            end
            oaids_pkg::REQ_SEARCH: begin
                if (count_reg != '0) begin
                    dec_target = oaids_pkg::ST_WALK;
                    dec_ptr    = '0;
                    dec_last   = cnt_m1[AW-1:0];
                end
            end
            oaids_pkg::REQ_READ: begin
                if (req.position >= count_reg) begin
                    dec_status = oaids_pkg::STS_RANGE;
                end else begin
                    dec_target = oaids_pkg::ST_WALK;
                    dec_ptr    = req.position[AW-1:0];
                    dec_last   = req.position[AW-1:0];
                end
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            oaids_pkg::ST_IDLE: begin
                if (req_valid) begin
                    state_next = dec_target;
                end
            end
            oaids_pkg::ST_WALK: begin
                if (ptr_reg == last_reg) begin
                    state_next = oaids_pkg::ST_TAIL;
                end
            end
            oaids_pkg::ST_TAIL: begin
                state_next = (kind_reg == oaids_pkg::REQ_INSERT) ? oaids_pkg::ST_PUT
                                                                  : oaids_pkg::ST_DONE;
            end
            oaids_pkg::ST_PUT: begin
                state_next = oaids_pkg::ST_DONE;
            end
            oaids_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = oaids_pkg::ST_IDLE;
                end
            end
            default: state_next = oaids_pkg::ST_IDLE;
        endcase
    end

    // outputs and RAM control
    always_comb begin
        req_ready = (state_reg == oaids_pkg::ST_IDLE);
        res_valid = (state_reg == oaids_pkg::ST_DONE);
        ram_re    = (state_reg == oaids_pkg::ST_WALK);
        ram_raddr = ptr_reg;
        ram_we    = (pend_reg && (kind_reg == oaids_pkg::REQ_INSERT ||
                                  kind_reg == oaids_pkg::REQ_DELETE))
                    || (state_reg == oaids_pkg::ST_PUT);
        if (state_reg == oaids_pkg::ST_PUT) begin
            ram_waddr = pos_reg;
            ram_wdata = value_reg;
        end else begin
            ram_waddr = (kind_reg == oaids_pkg::REQ_INSERT) ? paddr_reg + AW'(1)
                                                             : paddr_reg - AW'(1);
            ram_wdata = ram_rdata;
        end
        res.status     = status_reg;
        res.found      = found_reg;
        res.read_value = rdval_reg;
        res.count      = count_reg;
    end

    // datapath next values
    always_comb begin
        kind_next   = kind_reg;
        status_next = status_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        ptr_next    = ptr_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        rdval_next  = rdval_reg;
        pend_next   = (state_reg == oaids_pkg::ST_WALK);
        paddr_next  = ptr_reg;
        if (accept) begin
            kind_next   = req.kind;
            status_next = dec_status;
            value_next  = req.value;
            pos_next    = req.position[AW-1:0];
            ptr_next    = dec_ptr;
            last_next   = dec_last;
            count_next  = dec_count;
            found_next  = 1'b0;
            rdval_next  = '0;
        end else if (state_reg == oaids_pkg::ST_WALK) begin
            ptr_next = (kind_reg == oaids_pkg::REQ_INSERT) ? ptr_reg - AW'(1)
                                                            : ptr_reg + AW'(1);
        end
        if (pend_reg && kind_reg == oaids_pkg::REQ_SEARCH && ram_rdata == value_reg) begin
            found_next = 1'b1;
        end
        if (pend_reg && kind_reg == oaids_pkg::REQ_READ) begin
            rdval_next = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oaids_pkg::ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        ptr_reg    <= ptr_next;
        last_reg   <= last_next;
        paddr_reg  <= paddr_next;
        found_reg  <= found_next;
        rdval_reg  <= rdval_next;
    end

    `OAIDS_ASSERT_IMP(a_count_max, aclk, aresetn, 1'b1, count_reg <= CW'(oaids_pkg::CAPACITY))
    `OAIDS_ASSERT_IMP(a_no_rw_same, aclk, aresetn, ram_re && ram_we, ram_raddr != ram_waddr)
    `OAIDS_ASSERT_NXT(a_walk_pend, aclk, aresetn, state_reg == oaids_pkg::ST_WALK, pend_reg)
    `OAIDS_ASSERT_NXT(a_accept_busy, aclk, aresetn, accept, state_reg != oaids_pkg::ST_IDLE)

endmodule

@@ rtl/core/ordered_array_insert_delete_search_top.sv @@
// Ordered array block: packed entry RAM with insert, delete, search and read.
//
// The block keeps up to 256 signed 32-bit entries packed from address 0 in a
// single-port-read, single-port-write RAM, plus a fill count that reset
// clears (the RAM itself is not cleared; only entries below the count are
// ever read). One request is worked at a time, and the RAM is swept one
// entry per cycle, so the cost of a beat is set by how many entries it must
// touch through the one read port:
//   insert at position p : count - p shift moves, then the new entry is written
//   insert at the end    : the new entry is written with no shift
//   delete at position p : entries above p shift down, none for the last entry
//   search               : always scans every entry
//   read                 : reads the one entry at the position
//   any error, or search on an empty array : no RAM access
// Shifts move an entry per cycle: the read address runs two entries ahead
// of the write address, so no entry is written while it is read. The result
// is held in an output register; a new request is accepted while the
// previous result still waits there.
module ordered_array_insert_delete_search_top (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [8:0] position, [40:9] value, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [0] found, [32:1] read_value, [41:33] count
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int PW = oaids_pkg::POS_W;
    localparam int DW = oaids_pkg::DATA_W;
    localparam int CW = oaids_pkg::CNT_W;
    localparam int PAD_W = 48 - (1 + DW + CW);

    oaids_pkg::req_t req;
    oaids_pkg::res_t res;
    logic            res_valid;
    logic            res_ready;

    // output register state
    logic            out_vld_reg, out_vld_next;
    oaids_pkg::res_t out_reg, out_next;

    assign req.kind     = oaids_pkg::req_kind_t'(s_axis_tuser);
    assign req.position = s_axis_tdata[PW-1:0];
    assign req.value    = s_axis_tdata[PW+DW-1:PW];

    oaids_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // slot frees when empty or when the held beat leaves this cycle
    assign res_ready = !out_vld_reg || m_axis_tready;

    always_comb begin
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        if (res_valid && res_ready) begin
            out_vld_next = 1'b1;
            out_next     = res;
        end else if (m_axis_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_reg.count, out_reg.read_value, out_reg.found};

endmodule
